### sv/ebcaf_pkg.sv
// Package with word types and operation codes for the 8-bit CPU flag ALU.
package ebcaf_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_CP    = 5'd4,
        OP_AND   = 5'd5,
        OP_OR    = 5'd6,
        OP_XOR   = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_DAA   = 5'd10,
        OP_CPL   = 5'd11,
        OP_RLCA  = 5'd12,
        OP_RRCA  = 5'd13,
        OP_RLA   = 5'd14,
        OP_RRA   = 5'd15,
        OP_RLC   = 5'd16,
        OP_RRC   = 5'd17,
        OP_RL    = 5'd18,
        OP_RR    = 5'd19,
        OP_SLA   = 5'd20,
        OP_SRA   = 5'd21,
        OP_SRL   = 5'd22,
        OP_SWAP  = 5'd23,
        OP_BIT   = 5'd24,
        OP_RES   = 5'd25,
        OP_SET   = 5'd26,
        OP_ADD16 = 5'd27
    } op_t;

    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic        zero_in;
        logic        subtract_in;
        logic        half_carry_in;
        logic        carry_in;
    } in_word_t;

    typedef struct packed {
        logic [15:0] result;
        logic        writes_result;
        logic        zero_out;
        logic        subtract_out;
        logic        half_carry_out;
        logic        carry_out;
    } out_word_t;

endpackage

### sv/eight_bit_cpu_alu_with_flags_top.sv
// Top level of the 8-bit CPU flag ALU: input register, ALU logic, output register.
// An accepted word is held in the input register; its ALU result is registered for m_.
// Throughput: one word per cycle while the output is not stalled; each stage is
// a single register with short ALU logic between, so words stream without bubbles.
// A stalled output holds its word; the input register still takes a word when empty.
// Reset (aresetn low, synchronous) clears both stage valid bits; payload is not reset.
module eight_bit_cpu_alu_with_flags_top
    import ebcaf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    // Pipeline registers
    logic      s1_valid_reg, s1_valid_next;
    in_word_t  s1_word_reg, s1_word_next;
    logic      m_valid_reg, m_valid_next;
    out_word_t m_word_reg, m_word_next;

    logic      out_adv;   // output register can load this cycle
    logic      in_take;   // input word accepted
    out_word_t alu_word;  // ALU result for the word in the input register

    // Advance the output register when it is empty or being drained.
    assign out_adv = !m_valid_reg || m_ready;
    // Take a new word when the input register is empty or moves forward now.
    assign s_ready = !s1_valid_reg || out_adv;
    assign in_take = s_valid && s_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

    // ALU datapath, working on the input register
    logic [7:0]  a8, b8;
    logic        ci;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [7:0]  daa_val;
    logic        daa_carry;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [7:0]  bit_mask;
    logic [7:0]  r8;

    always_comb begin
        a8       = s1_word_reg.operand_a[7:0];
        b8       = s1_word_reg.operand_b[7:0];
        bit_mask = 8'b1 << s1_word_reg.bit_index;
        sum9     = '0;
        nib5     = '0;
        ci       = 1'b0;
        daa_val  = a8;
        daa_carry = s1_word_reg.carry_in;
        sum17    = {1'b0, s1_word_reg.operand_a} + {1'b0, s1_word_reg.operand_b};
        sum13    = {1'b0, s1_word_reg.operand_a[11:0]} + {1'b0, s1_word_reg.operand_b[11:0]};
        r8       = '0;

        // Default: pass flags, write back a zero result
        alu_word.result         = '0;
        alu_word.writes_result  = 1'b1;
        alu_word.zero_out       = s1_word_reg.zero_in;
        alu_word.subtract_out   = s1_word_reg.subtract_in;
        alu_word.half_carry_out = s1_word_reg.half_carry_in;
        alu_word.carry_out      = s1_word_reg.carry_in;

        unique case (op_t'(s1_word_reg.opcode))
            OP_ADD, OP_ADC: begin
                ci   = (op_t'(s1_word_reg.opcode) == OP_ADC) ? s1_word_reg.carry_in : 1'b0;
                sum9 = {1'b0, a8} + {1'b0, b8} + {8'b0, ci};
                nib5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'b0, ci};
                r8   = sum9[7:0];
                alu_word.result         = {8'b0, r8};
                alu_word.zero_out       = (r8 == 8'b0);
                alu_word.subtract_out   = 1'b0;
                alu_word.half_carry_out = nib5[4];
                alu_word.carry_out      = sum9[8];
            end
            OP_SUB, OP_SBC, OP_CP: begin
                ci   = (op_t'(s1_word_reg.opcode) == OP_SBC) ? s1_word_reg.carry_in : 1'b0;
                // Borrow shows up as the sign bit of the widened difference
                sum9 = {1'b0, a8} - {1'b0, b8} - {8'b0, ci};
                nib5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'b0, ci};
                r8   = sum9[7:0];
                alu_word.zero_out       = (r8 == 8'b0);
                alu_word.subtract_out   = 1'b1;
                alu_word.half_carry_out = nib5[4];
                alu_word.carry_out      = sum9[8];
                if (op_t'(s1_word_reg.opcode) == OP_CP) begin
                    alu_word.writes_result = 1'b0;
                end else begin
                    alu_word.result = {8'b0, r8};
                end
            end
            OP_AND: begin
                r8 = a8 & b8;
                alu_word.result         = {8'b0, r8};
                alu_word.zero_out       = (r8 == 8'b0);
                alu_word.subtract_out   = 1'b0;
                alu_word.half_carry_out = 1'b1;
                alu_word.carry_out      = 1'b0;
            end
            OP_OR, OP_XOR: begin
                r8 = (op_t'(s1_word_reg.opcode) == OP_OR) ? (a8 | b8) : (a8 ^ b8);
                alu_word.result         = {8'b0, r8};
                alu_word.zero_out       = (r8 == 8'b0);
                alu_word.subtract_out   = 1'b0;
                alu_word.half_carry_out = 1'b0;
                alu_word.carry_out      = 1'b0;
            end
            OP_INC: begin
                r8 = b8 + 8'd1;
                alu_word.result         = {8'b0, r8};
                alu_word.zero_out       = (r8 == 8'b0);
                alu_word.subtract_out   = 1'b0;
                alu_word.half_carry_out = (b8[3:0] == 4'hF);
            end
            OP_DEC: begin
                r8 = b8 - 8'd1;
                alu_word.result         = {8'b0, r8};
                alu_word.zero_out       = (r8 == 8'b0);
                alu_word.subtract_out   = 1'b1;
                alu_word.half_carry_out = (b8[3:0] == 4'h0);
            end
            OP_DAA: begin
                if (!s1_word_reg.subtract_in) begin
                    if (s1_word_reg.carry_in || (a8 > DAA_HI_LIMIT)) begin
                        daa_val   = daa_val + DAA_HI_ADJ;
                        daa_carry = 1'b1;
                    end
                    if (s1_word_reg.half_carry_in || (a8[3:0] > DAA_LO_LIMIT)) begin
                        daa_val = daa_val + DAA_LO_ADJ;
                    end
                end else begin
                    if (s1_word_reg.carry_in) begin
                        daa_val = daa_val - DAA_HI_ADJ;
                    end
                    if (s1_word_reg.half_carry_in) begin
                        daa_val = daa_val - DAA_LO_ADJ;
                    end
                end
                alu_word.result         = {8'b0, daa_val};
                alu_word.zero_out       = (daa_val == 8'b0);
                alu_word.half_carry_out = 1'b0;
                alu_word.carry_out      = daa_carry;
            end
            OP_CPL: begin
                alu_word.result         = {8'b0, ~a8};
                alu_word.subtract_out   = 1'b1;
                alu_word.half_carry_out = 1'b1;
            end
            // Accumulator rotates always clear zero
            OP_RLCA: begin
                alu_word.result         = {8'b0, a8[6:0], a8[7]};
                alu_word.zero_out       = 1'b0;
                alu_word.subtract_out   = 1'b0;
                alu_word.half_carry_out = 1'b0;
                alu_word.carry_out      = a8[7];
            end
            OP_RRCA: begin
                alu_word.result         = {8'b0, a8[0], a8[7:1]};
                alu_word.zero_out       = 1'b0;
                alu_word.subtract_out   = 1'b0;
                alu_word.half_carry_out = 1'b0;
                alu_word.carry_out      = a8[0];
            end
            OP_RLA: begin
                alu_word.result         = {8'b0, a8[6:0], s1_word_reg.carry_in};
                alu_word.zero_out       = 1'b0;
                alu_word.subtract_out   = 1'b0;
                alu_word.half_carry_out = 1'b0;
                alu_word.carry_out      = a8[7];
            end
            OP_RRA: begin
                alu_word.result         = {8'b0, s1_word_reg.carry_in, a8[7:1]};
                alu_word.zero_out       = 1'b0;
                alu_word.subtract_out   = 1'b0;
                alu_word.half_carry_out = 1'b0;
                alu_word.carry_out      = a8[0];
            end
            // Prefixed rotates, shifts and swap act on operand b
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL, OP_SWAP: begin
                unique case (op_t'(s1_word_reg.opcode))
                    OP_RLC: begin
                        r8 = {b8[6:0], b8[7]};
                        alu_word.carry_out = b8[7];
                    end
                    OP_RRC: begin
                        r8 = {b8[0], b8[7:1]};
                        alu_word.carry_out = b8[0];
                    end
                    OP_RL: begin
                        r8 = {b8[6:0], s1_word_reg.carry_in};
                        alu_word.carry_out = b8[7];
                    end
                    OP_RR: begin
                        r8 = {s1_word_reg.carry_in, b8[7:1]};
                        alu_word.carry_out = b8[0];
                    end
                    OP_SLA: begin
                        r8 = {b8[6:0], 1'b0};
                        alu_word.carry_out = b8[7];
                    end
                    OP_SRA: begin
                        r8 = {b8[7], b8[7:1]};
                        alu_word.carry_out = b8[0];
                    end
                    OP_SRL: begin
                        r8 = {1'b0, b8[7:1]};
                        alu_word.carry_out = b8[0];
                    end
                    default: begin
                        r8 = {b8[3:0], b8[7:4]};
                        alu_word.carry_out = 1'b0;
                    end
                endcase
                alu_word.result         = {8'b0, r8};
                alu_word.zero_out       = (r8 == 8'b0);
                alu_word.subtract_out   = 1'b0;
                alu_word.half_carry_out = 1'b0;
            end
            OP_BIT: begin
                alu_word.writes_result  = 1'b0;
                alu_word.zero_out       = !b8[s1_word_reg.bit_index];
                alu_word.subtract_out   = 1'b0;
                alu_word.half_carry_out = 1'b1;
            end
            OP_RES: begin
                alu_word.result = {8'b0, b8 & ~bit_mask};
            end
            OP_SET: begin
                alu_word.result = {8'b0, b8 | bit_mask};
            end
            OP_ADD16: begin
                alu_word.result         = sum17[15:0];
                alu_word.subtract_out   = 1'b0;
                alu_word.half_carry_out = sum13[12];
                alu_word.carry_out      = sum17[16];
            end
            default: begin
                // Unused codes: no write, flags pass through
                alu_word.writes_result = 1'b0;
            end
        endcase
    end

    // Stage control: load on accept, hold when the output stalls, drop when drained.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_word_next  = s1_word_reg;
        m_valid_next  = m_valid_reg;
        m_word_next   = m_word_reg;
        if (out_adv) begin
            m_valid_next = s1_valid_reg;
            m_word_next  = alu_word;
            s1_valid_next = 1'b0;
        end
        if (in_take) begin
            s1_valid_next = 1'b1;
            s1_word_next  = s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        s1_word_reg <= s1_word_next;
        m_word_reg  <= m_word_next;
    end

    // Input side stalls only when both stages are full and the output is held.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a full, held pipeline");

    // An accepted word always lands in the input register.
    a_take_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid_reg)
        else $error("accepted word lost");

    // A word blocked in the input register keeps its payload.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_adv) |=> (s1_valid_reg && $stable(s1_word_reg)))
        else $error("input register changed while blocked");

    // Compare never writes back and shows a zero result.
    a_cp_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_adv && s1_valid_reg && (s1_word_reg.opcode == OP_CP))
        |=> (m_valid_reg && !m_word_reg.writes_result && (m_word_reg.result == 16'h0)))
        else $error("compare result written back");

endmodule

### tb/tb_eight_bit_cpu_alu_with_flags_top.sv
// Self-checking testbench for the 8-bit CPU flag ALU: directed table, random words, scoreboard.
module tb_eight_bit_cpu_alu_with_flags_top;
    import ebcaf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes 28 to 31 have no operation; the block must pass the flags through.
    localparam logic [4:0] OP_FIRST_UNUSED = 5'd28;

    localparam int IDLE_PCT     = 24;    // percent of cycles each side idles
    localparam int RANDOM_WORDS = 1120;
    localparam int CALM_FROM    = 500;   // random words in [CALM_FROM, CALM_TO) never idle
    localparam int CALM_TO      = 700;
    localparam int HOLDOFF_AT   = 400;   // receiver cycle at which the long hold-off starts
    localparam int HOLDOFF_LEN  = 150;
    localparam int STALL_LIMIT  = 2000;  // cycles without any handshake before giving up
    localparam int DRAIN_TAIL   = 8;     // pipeline is two deep; leave a margin

    // One row of the directed table; a typed-in expectation overrides the predictor.
    typedef struct packed {
        in_word_t  stim;
        logic      has_exp;
        out_word_t exp;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    // Travel with s_data so the scoreboard sees them at the accepting edge.
    logic      typed_exp_valid;
    out_word_t typed_exp;
    // Shared with the receiver: both sides stop idling while this is high.
    logic      calm_phase;

    out_word_t   expected_results[$];
    stim_row_t   directed_rows[$];
    int          mismatch_count;
    int unsigned result_idx;
    int unsigned quiet_cycles;

    eight_bit_cpu_alu_with_flags_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Word builders; flags are packed as {Z, N, H, C}.
    // ------------------------------------------------------------------
    function automatic in_word_t make_in_word(logic [4:0] op, logic [15:0] a, logic [15:0] b,
                                              logic [2:0] bi, logic [3:0] flags);
        in_word_t w;
        w.opcode    = op;
        w.operand_a = a;
        w.operand_b = b;
        w.bit_index = bi;
        {w.zero_in, w.subtract_in, w.half_carry_in, w.carry_in} = flags;
        return w;
    endfunction

    function automatic out_word_t make_out_word(logic [15:0] res, logic wr, logic [3:0] flags);
        out_word_t o;
        o.result        = res;
        o.writes_result = wr;
        {o.zero_out, o.subtract_out, o.half_carry_out, o.carry_out} = flags;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: result word and new flags for one ALU word.
    // ------------------------------------------------------------------
    function automatic out_word_t predict_alu(in_word_t w);
        out_word_t   o;
        logic [7:0]  a, b, v, r;
        logic [8:0]  sum9;
        logic [12:0] sum13;
        logic [16:0] sum17;
        logic        ci, z, n, h, c, wr;
        a     = w.operand_a[7:0];
        b     = w.operand_b[7:0];
        z     = w.zero_in;
        n     = w.subtract_in;
        h     = w.half_carry_in;
        c     = w.carry_in;
        r     = 8'h00;
        wr    = 1'b1;
        sum17 = '0;
        // Accumulator rotates work on A, the prefixed ones on the second operand.
        v     = (w.opcode < OP_RLC) ? a : b;
        ci    = (w.opcode == OP_ADC || w.opcode == OP_SBC) ? w.carry_in : 1'b0;
        case (w.opcode)
            OP_ADD, OP_ADC: begin
                sum9 = {1'b0, a} + {1'b0, b} + {8'b0, ci};
                h    = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, ci}) > 5'h0f;
                c    = sum9[8];
                r    = sum9[7:0];
                z    = (r == 8'h00);
                n    = 1'b0;
            end
            OP_SUB, OP_SBC, OP_CP: begin
                h = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'b0, ci});
                c = {1'b0, a} < ({1'b0, b} + {8'b0, ci});
                r = a - b - {7'b0, ci};
                z = (r == 8'h00);
                n = 1'b1;
                if (w.opcode == OP_CP) begin
                    r  = 8'h00;
                    wr = 1'b0;
                end
            end
            OP_AND: begin
                r = a & b;
                z = (r == 8'h00); n = 1'b0; h = 1'b1; c = 1'b0;
            end
            OP_OR, OP_XOR: begin
                r = (w.opcode == OP_OR) ? (a | b) : (a ^ b);
                z = (r == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
            end
            OP_INC: begin
                r = b + 8'h01;
                z = (r == 8'h00); n = 1'b0; h = (b[3:0] == 4'hf);
            end
            OP_DEC: begin
                r = b - 8'h01;
                z = (r == 8'h00); n = 1'b1; h = (b[3:0] == 4'h0);
            end
            OP_DAA: begin
                r = a;
                if (!n) begin
                    if (c || a > DAA_HI_LIMIT) begin
                        r = r + DAA_HI_ADJ;
                        c = 1'b1;
                    end
                    if (h || a[3:0] > DAA_LO_LIMIT) r = r + DAA_LO_ADJ;
                end else begin
                    if (c) r = r - DAA_HI_ADJ;
                    if (h) r = r - DAA_LO_ADJ;
                end
                z = (r == 8'h00);
                h = 1'b0;
            end
            OP_CPL: begin
                r = ~a;
                n = 1'b1; h = 1'b1;
            end
            OP_RLCA, OP_RLC: begin r = {v[6:0], v[7]}; c = v[7]; end
            OP_RRCA, OP_RRC: begin r = {v[0], v[7:1]}; c = v[0]; end
            OP_RLA,  OP_RL:  begin r = {v[6:0], c};    c = v[7]; end
            OP_RRA,  OP_RR:  begin r = {c, v[7:1]};    c = v[0]; end
            OP_SLA:          begin r = {v[6:0], 1'b0}; c = v[7]; end
            OP_SRA:          begin r = {v[7], v[7:1]}; c = v[0]; end
            OP_SRL:          begin r = {1'b0, v[7:1]}; c = v[0]; end
            OP_SWAP:         begin r = {v[3:0], v[7:4]}; c = 1'b0; end
            OP_BIT: begin
                z  = ~b[w.bit_index];
                n  = 1'b0; h = 1'b1;
                wr = 1'b0;
            end
            OP_RES: r = b & ~(8'h01 << w.bit_index);
            OP_SET: r = b | (8'h01 << w.bit_index);
            OP_ADD16: begin
                sum17 = {1'b0, w.operand_a} + {1'b0, w.operand_b};
                sum13 = {1'b0, w.operand_a[11:0]} + {1'b0, w.operand_b[11:0]};
                h     = sum13[12];
                c     = sum17[16];
                n     = 1'b0;
            end
            default: wr = 1'b0;
        endcase
        // All twelve rotate and shift forms share N, H and the zero rule.
        if (w.opcode >= OP_RLCA && w.opcode <= OP_SWAP) begin
            n = 1'b0;
            h = 1'b0;
            z = (w.opcode < OP_RLC) ? 1'b0 : (r == 8'h00);
        end
        o.result         = (w.opcode == OP_ADD16) ? sum17[15:0] : {8'h00, r};
        o.writes_result  = wr;
        o.zero_out       = z;
        o.subtract_out   = n;
        o.half_carry_out = h;
        o.carry_out      = c;
        return o;
    endfunction

    // Pick an operand: mostly random, often with a corner value in the low byte.
    function automatic logic [15:0] pick_operand();
        logic [31:0] rnd;
        logic [15:0] x;
        rnd = $urandom;
        x   = rnd[15:0];
        case ($urandom_range(0, 11))
            0:  x = 16'h0000;
            1:  x = 16'hffff;
            2:  x[7:0] = 8'h00;
            3:  x[7:0] = 8'hff;
            4:  x[7:0] = 8'h0f;
            5:  x[7:0] = 8'hf0;
            6:  x[7:0] = 8'h99;
            7:  x[7:0] = 8'h80;
            8:  x[11:0] = 12'hfff;
            default: ;
        endcase
        return x;
    endfunction

    task automatic add_row(in_word_t stim, logic has_exp, out_word_t exp);
        stim_row_t row;
        row.stim    = stim;
        row.has_exp = has_exp;
        row.exp     = exp;
        directed_rows.push_back(row);
    endtask

    // Count one mismatch and print it on one line.
    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("MISMATCH: %s", what);
    endtask

    // ------------------------------------------------------------------
    // Sender: hold valid and payload until the word is taken.
    // ------------------------------------------------------------------
    task automatic offer_word(in_word_t w, logic has_exp, out_word_t exp);
        s_valid         <= 1'b1;
        s_data          <= w;
        typed_exp_valid <= has_exp;
        typed_exp       <= exp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid for a random number of cycles before the next word.
    task automatic idle_gap(int pct);
        while ($urandom_range(0, 99) < pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    initial begin : stimulus
        in_word_t w;
        int       pct;
        logic     calm;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        typed_exp_valid = 1'b0;
        typed_exp       = '0;
        calm_phase      = 1'b0;

        // Directed table: extremes, every operation, and the special cases.
        add_row(make_in_word(OP_ADD,   16'h0000, 16'h0000, 3'd0, 4'b0000), 1'b1,
                make_out_word(16'h0000, 1'b1, 4'b1000));
        add_row(make_in_word(OP_ADD,   16'hffff, 16'hff01, 3'd0, 4'b0100), 1'b1,
                make_out_word(16'h0000, 1'b1, 4'b1011));
        add_row(make_in_word(OP_ADC,   16'h00ff, 16'h00ff, 3'd0, 4'b0001), 1'b0, '0);
        add_row(make_in_word(OP_SUB,   16'h0000, 16'h0001, 3'd0, 4'b0000), 1'b1,
                make_out_word(16'h00ff, 1'b1, 4'b0111));
        add_row(make_in_word(OP_SBC,   16'h0010, 16'h000f, 3'd0, 4'b0001), 1'b0, '0);
        // Compare writes nothing back and leaves the result field clear.
        add_row(make_in_word(OP_CP,    16'h0042, 16'h0042, 3'd0, 4'b0000), 1'b1,
                make_out_word(16'h0000, 1'b0, 4'b1100));
        add_row(make_in_word(OP_AND,   16'h00f0, 16'h000f, 3'd0, 4'b0101), 1'b1,
                make_out_word(16'h0000, 1'b1, 4'b1010));
        add_row(make_in_word(OP_OR,    16'h005a, 16'h00a5, 3'd0, 4'b1111), 1'b0, '0);
        add_row(make_in_word(OP_XOR,   16'h00ff, 16'h00ff, 3'd0, 4'b0111), 1'b1,
                make_out_word(16'h0000, 1'b1, 4'b1000));
        // Increment and decrement keep the carry.
        add_row(make_in_word(OP_INC,   16'hffff, 16'h00ff, 3'd0, 4'b0001), 1'b1,
                make_out_word(16'h0000, 1'b1, 4'b1011));
        add_row(make_in_word(OP_DEC,   16'h0000, 16'hff00, 3'd0, 4'b0000), 1'b1,
                make_out_word(16'h00ff, 1'b1, 4'b0110));
        // Decimal adjust after addition, with and without incoming flags, and after subtraction.
        add_row(make_in_word(OP_DAA,   16'h009a, 16'h0000, 3'd0, 4'b0000), 1'b0, '0);
        add_row(make_in_word(OP_DAA,   16'h0000, 16'h0000, 3'd0, 4'b0011), 1'b0, '0);
        add_row(make_in_word(OP_DAA,   16'h0000, 16'h0000, 3'd0, 4'b0111), 1'b0, '0);
        add_row(make_in_word(OP_CPL,   16'h0000, 16'h0000, 3'd0, 4'b1001), 1'b1,
                make_out_word(16'h00ff, 1'b1, 4'b1111));
        // Accumulator rotates always clear Z.
        add_row(make_in_word(OP_RLCA,  16'h0080, 16'h0000, 3'd0, 4'b1111), 1'b1,
                make_out_word(16'h0001, 1'b1, 4'b0001));
        add_row(make_in_word(OP_RRCA,  16'h0001, 16'h0000, 3'd0, 4'b1000), 1'b0, '0);
        add_row(make_in_word(OP_RLA,   16'h0080, 16'h0000, 3'd0, 4'b0000), 1'b0, '0);
        add_row(make_in_word(OP_RRA,   16'h0001, 16'h0000, 3'd0, 4'b0001), 1'b0, '0);
        add_row(make_in_word(OP_RLC,   16'h00ff, 16'h0000, 3'd0, 4'b0001), 1'b1,
                make_out_word(16'h0000, 1'b1, 4'b1000));
        add_row(make_in_word(OP_RRC,   16'h0000, 16'h0001, 3'd0, 4'b0000), 1'b0, '0);
        add_row(make_in_word(OP_RL,    16'h0000, 16'h0080, 3'd0, 4'b0000), 1'b0, '0);
        add_row(make_in_word(OP_RR,    16'h0000, 16'hff01, 3'd0, 4'b0001), 1'b0, '0);
        add_row(make_in_word(OP_SLA,   16'h0000, 16'h0080, 3'd0, 4'b0000), 1'b0, '0);
        add_row(make_in_word(OP_SRA,   16'h0000, 16'h0081, 3'd0, 4'b0000), 1'b0, '0);
        add_row(make_in_word(OP_SRL,   16'h0000, 16'h0001, 3'd0, 4'b0000), 1'b0, '0);
        add_row(make_in_word(OP_SWAP,  16'h0000, 16'h00f0, 3'd0, 4'b0001), 1'b0, '0);
        // Bit test writes nothing back; res and set keep every flag.
        add_row(make_in_word(OP_BIT,   16'h0000, 16'h007f, 3'd7, 4'b0001), 1'b1,
                make_out_word(16'h0000, 1'b0, 4'b1011));
        add_row(make_in_word(OP_RES,   16'h0000, 16'h00ff, 3'd0, 4'b1111), 1'b1,
                make_out_word(16'h00fe, 1'b1, 4'b1111));
        add_row(make_in_word(OP_SET,   16'h0000, 16'h0000, 3'd7, 4'b0000), 1'b1,
                make_out_word(16'h0080, 1'b1, 4'b0000));
        // 16-bit add keeps Z and takes H from bit 11.
        add_row(make_in_word(OP_ADD16, 16'hffff, 16'h0001, 3'd0, 4'b1000), 1'b1,
                make_out_word(16'h0000, 1'b1, 4'b1011));
        add_row(make_in_word(OP_ADD16, 16'h0fff, 16'h0001, 3'd0, 4'b0100), 1'b0, '0);
        // Unused codes pass all flags through.
        add_row(make_in_word(OP_FIRST_UNUSED, 16'hffff, 16'hffff, 3'd7, 4'b0101), 1'b1,
                make_out_word(16'h0000, 1'b0, 4'b0101));
        add_row(make_in_word(OP_FIRST_UNUSED + 5'd3, 16'h1234, 16'h5678, 3'd3, 4'b1010), 1'b1,
                make_out_word(16'h0000, 1'b0, 4'b1010));

        // Hold reset low, then release it for good.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table.
        foreach (directed_rows[i]) begin
            idle_gap(IDLE_PCT);
            offer_word(directed_rows[i].stim, directed_rows[i].has_exp, directed_rows[i].exp);
        end

        // Random words, all checked against the predictor; one window runs without idling.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            calm = (i >= CALM_FROM && i < CALM_TO);
            calm_phase <= calm;
            pct = calm ? 0 : IDLE_PCT;
            idle_gap(pct);
            w = make_in_word(5'($urandom_range(0, 31)), pick_operand(), pick_operand(),
                             3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
            offer_word(w, 1'b0, '0);
        end
        s_valid <= 1'b0;

        // Drain: let the scoreboard queue the last word, wait for every expected word,
        // then wait out the drain margin before ending the run.
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, one long hold-off, none in the calm window.
    // ------------------------------------------------------------------
    initial begin : receiver
        int unsigned rx_cycle;
        m_ready  = 1'b0;
        rx_cycle = 0;
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (rx_cycle == HOLDOFF_AT) begin
                // Hold off while the sender keeps offering, so both stages fill and
                // s_ready drops.
                m_ready <= 1'b0;
                repeat (HOLDOFF_LEN) @(posedge aclk);
                rx_cycle += HOLDOFF_LEN;
            end else if (calm_phase) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: queue a prediction per accepted input word, check each output word.
    // ------------------------------------------------------------------
    initial begin
        mismatch_count = 0;
        result_idx     = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(typed_exp_valid ? typed_exp : predict_alu(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("word %0d arrived with nothing expected: %h",
                                              result_idx, m_data));
                end else begin
                    out_word_t want;
                    want = expected_results.pop_front();
                    if (m_data.result !== want.result)
                        report_mismatch($sformatf("word %0d result: got %h, want %h",
                                                  result_idx, m_data.result, want.result));
                    if (m_data.writes_result !== want.writes_result)
                        report_mismatch($sformatf("word %0d writes_result: got %b, want %b",
                                                  result_idx, m_data.writes_result,
                                                  want.writes_result));
                    if (m_data.zero_out !== want.zero_out)
                        report_mismatch($sformatf("word %0d zero_out: got %b, want %b",
                                                  result_idx, m_data.zero_out, want.zero_out));
                    if (m_data.subtract_out !== want.subtract_out)
                        report_mismatch($sformatf("word %0d subtract_out: got %b, want %b",
                                                  result_idx, m_data.subtract_out,
                                                  want.subtract_out));
                    if (m_data.half_carry_out !== want.half_carry_out)
                        report_mismatch($sformatf("word %0d half_carry_out: got %b, want %b",
                                                  result_idx, m_data.half_carry_out,
                                                  want.half_carry_out));
                    if (m_data.carry_out !== want.carry_out)
                        report_mismatch($sformatf("word %0d carry_out: got %b, want %b",
                                                  result_idx, m_data.carry_out,
                                                  want.carry_out));
                end
                result_idx++;
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    initial quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TIMEOUT: no handshake for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule

### eight_bit_cpu_alu_with_flags_top.f
sv/ebcaf_pkg.sv
sv/eight_bit_cpu_alu_with_flags_top.sv
tb/tb_eight_bit_cpu_alu_with_flags_top.sv
